@@ rtl/bat_pkg.sv @@
// ----------------------------------------------------------------------------
// bat_pkg
// Shared types and constants of the band-averaged table lookup core.
// ----------------------------------------------------------------------------
`default_nettype none

package bat_pkg;

  // Width of one stored table value, unsigned Q16.24
  localparam int VAL_W = 40;

  // Width of index arithmetic before clamping (wavelength plus half band)
  localparam int IW = 17;

  // Fixed-point shift of the reciprocal used to divide by the wavelength step
  localparam int RECIP_SHIFT = 21;

  // Item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [0:0] REG_FIRST_WL = 1'b0;
  localparam logic [0:0] REG_ENTRIES  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [11:0] FIRST_WL_RST = 12'd200;
  localparam logic [12:0] ENTRIES_RST  = 13'd2250;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_WINDOW,
    ST_READ,
    ST_DRAIN,
    ST_START,
    ST_DIV,
    ST_HOLD
  } bat_state_e;

  // Divider result toward the sequencer
  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quo_a;
    logic [VAL_W-1:0] quo_b;
  } bat_div_res_t;

endpackage

`default_nettype wire

@@ rtl/bat_table_mem.sv @@
// ----------------------------------------------------------------------------
// bat_table_mem
// Synchronous table memory: one write port, one read port, registered read.
// Each word holds an absorption value and a halved backscatter value.
// ----------------------------------------------------------------------------
`default_nettype none

module bat_table_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [AW-1:0]            waddr_i,
  input  wire  [bat_pkg::VAL_W-1:0] wabs_i,
  input  wire  [bat_pkg::VAL_W-1:0] wbsc_i,
  input  wire                      re_i,
  input  wire  [AW-1:0]            raddr_i,
  output logic [bat_pkg::VAL_W-1:0] rabs_o,
  output logic [bat_pkg::VAL_W-1:0] rbsc_o
);
  import bat_pkg::*;

  logic [2*VAL_W-1:0] tbl_q [DEPTH];
  logic [2*VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      tbl_q[waddr_i] <= {wabs_i, wbsc_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= tbl_q[raddr_i];
    end
  end

  assign rabs_o = rdata_q[2*VAL_W-1:VAL_W];
  assign rbsc_o = rdata_q[VAL_W-1:0];

endmodule

`default_nettype wire

@@ rtl/bat_divider.sv @@
// ----------------------------------------------------------------------------
// bat_divider
// Two-lane restoring divider, one quotient bit per lane and cycle.
// Both window sums share one divisor, the entry count.
// ----------------------------------------------------------------------------
`default_nettype none

module bat_divider #(
  parameter int SUM_W = 52,
  parameter int CNT_W = 13
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start_i,
  input  wire  [SUM_W-1:0]          sum_a_i,
  input  wire  [SUM_W-1:0]          sum_b_i,
  input  wire  [CNT_W-1:0]          count_i,
  output bat_pkg::bat_div_res_t     res_o
);
  import bat_pkg::*;

  localparam int CW = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] num_q [2];
  logic [SUM_W-1:0] num_d [2];
  logic [CNT_W-1:0] rem_q [2];
  logic [CNT_W-1:0] rem_d [2];
  logic [CNT_W:0]   trial [2];
  logic [CNT_W-1:0] div_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l] = {rem_q[l], num_q[l][SUM_W-1]};
      if (trial[l] >= {1'b0, div_q}) begin
        rem_d[l] = CNT_W'(trial[l] - {1'b0, div_q});
        num_d[l] = {num_q[l][SUM_W-2:0], 1'b1};
      end else begin
        rem_d[l] = trial[l][CNT_W-1:0];
        num_d[l] = {num_q[l][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(SUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q[0] <= sum_a_i;
      num_q[1] <= sum_b_i;
      rem_q[0] <= '0;
      rem_q[1] <= '0;
      div_q    <= count_i;
    end else if (busy_q) begin
      num_q[0] <= num_d[0];
      num_q[1] <= num_d[1];
      rem_q[0] <= rem_d[0];
      rem_q[1] <= rem_d[1];
    end
  end

  // The mean never exceeds the largest entry, so the low bits hold it whole
  assign res_o.done  = done_q;
  assign res_o.quo_a = num_q[0][VAL_W-1:0];
  assign res_o.quo_b = num_q[1][VAL_W-1:0];

endmodule

`default_nettype wire

@@ rtl/band_averaged_table_lookup_core.sv @@
// ----------------------------------------------------------------------------
// band_averaged_table_lookup_core
// Absorption and backscatter tables with band-averaged queries.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   in      | input     | in_valid_i / in_stall_o | func, entry, values, wl, bw
//   out     | output    | out_valid_o/out_stall_i | two means, entries averaged
//   cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// A load item writes both tables at its accept edge.
// A query passes the scale, window, read, drain, start, divide and hold states;
// it reads one averaged entry per cycle, then one quotient bit per divider step.
// The result sits in an output register; the next item is taken while it waits.
// Reset clears control only; table entries are undefined until loaded.
// A stalled result holds the block in its last state until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module band_averaged_table_lookup_core #(
  parameter int TABLE_DEPTH = 4096,
  parameter int STEP_NM     = 1
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [0:0]  cfg_idx_i,
  input  wire  [12:0] cfg_wdata_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         func_i,
  input  wire  [11:0] entry_index_i,
  input  wire  [39:0] absorption_value_i,
  input  wire  [39:0] scatter_value_i,
  input  wire  [15:0] wavelength_nm_i,
  input  wire  [12:0] bandwidth_nm_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [39:0] mean_absorption_o,
  output logic [39:0] mean_backscatter_o,
  output logic [12:0] entries_averaged_o
);
  import bat_pkg::*;

  localparam int AW        = $clog2(TABLE_DEPTH);
  localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int SUM_W     = VAL_W + AW;
  localparam int RECIP_W   = RECIP_SHIFT + 1;
  localparam int PW        = 16 + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << RECIP_SHIFT) + STEP_NM - 1) / STEP_NM);

  bat_state_e       state_q, state_d;
  logic [11:0]      cfg_first_wl_q;
  logic [12:0]      cfg_entries_q;
  logic [15:0]      diff_q;
  logic             below_q;
  logic [11:0]      half_raw_q;
  logic [IW-1:0]    centre_q;
  logic [IW-1:0]    half_q;
  logic [AW-1:0]    rd_addr_q;
  logic [AW-1:0]    hi_q;
  logic [CNT_W-1:0] count_q;
  logic             rd_pend_q;
  logic [SUM_W-1:0] sum_a_q;
  logic [SUM_W-1:0] sum_b_q;
  logic             out_valid_q;

  logic             in_accept;
  logic             mem_we;
  logic [16:0]      diff_c;
  logic [PW-1:0]    prod_wl;
  logic [PW-1:0]    prod_hw;
  logic [IW-1:0]    n_m1;
  logic [IW-1:0]    centre_cl;
  logic [IW-1:0]    lo_c;
  logic [IW-1:0]    hi_sum;
  logic [IW-1:0]    hi_c;
  logic             mem_re;
  logic [VAL_W-1:0] rabs;
  logic [VAL_W-1:0] rbsc;
  logic             div_start;
  bat_div_res_t     div_res;
  logic             out_load;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign mem_we     = in_accept && (func_i == FUNC_LOAD)
                      && (32'(entry_index_i) < TABLE_DEPTH);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_first_wl_q <= FIRST_WL_RST;
      cfg_entries_q  <= ENTRIES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FIRST_WL: cfg_first_wl_q <= cfg_wdata_i[11:0];
        REG_ENTRIES:  cfg_entries_q  <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  // Last usable index, entries saturated to one through the table depth
  always_comb begin
    if (cfg_entries_q == 13'd0) begin
      n_m1 = '0;
    end else if (32'(cfg_entries_q) > TABLE_DEPTH) begin
      n_m1 = IW'(TABLE_DEPTH - 1);
    end else begin
      n_m1 = IW'(cfg_entries_q) - IW'(1);
    end
  end

  assign diff_c  = {1'b0, wavelength_nm_i} - {5'b0, cfg_first_wl_q};
  assign prod_wl = PW'(diff_q) * PW'(RECIP);
  assign prod_hw = PW'(half_raw_q) * PW'(RECIP);

  // Window bounds: clamp the centre first, then clip both ends
  always_comb begin
    if (below_q) begin
      centre_cl = '0;
    end else if (centre_q > n_m1) begin
      centre_cl = n_m1;
    end else begin
      centre_cl = centre_q;
    end
    lo_c   = (centre_cl > half_q) ? (centre_cl - half_q) : '0;
    hi_sum = centre_cl + half_q;
    hi_c   = (hi_sum > n_m1) ? n_m1 : hi_sum;
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mem_re    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && (func_i == FUNC_QUERY)) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE:  state_d = ST_WINDOW;
      ST_WINDOW: state_d = ST_READ;
      ST_READ: begin
        mem_re = 1'b1;
        if (rd_addr_q == hi_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_START;
      ST_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q   <= mem_re;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      diff_q     <= diff_c[15:0];
      below_q    <= diff_c[16];
      half_raw_q <= bandwidth_nm_i[12:1];
    end
    if (state_q == ST_SCALE) begin
      centre_q <= IW'(prod_wl >> RECIP_SHIFT);
      half_q   <= IW'(prod_hw >> RECIP_SHIFT);
    end
    if (state_q == ST_WINDOW) begin
      rd_addr_q <= AW'(lo_c);
      hi_q      <= AW'(hi_c);
      count_q   <= CNT_W'(hi_c - lo_c) + CNT_W'(1);
      sum_a_q   <= '0;
      sum_b_q   <= '0;
    end else if (rd_pend_q) begin
      sum_a_q <= sum_a_q + SUM_W'(rabs);
      sum_b_q <= sum_b_q + SUM_W'(rbsc);
    end
    if (mem_re && (rd_addr_q != hi_q)) begin
      rd_addr_q <= rd_addr_q + AW'(1);
    end
    if (out_load) begin
      mean_absorption_o  <= div_res.quo_a;
      mean_backscatter_o <= div_res.quo_b;
      entries_averaged_o <= 13'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;

  bat_table_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(entry_index_i)),
    .wabs_i  (absorption_value_i),
    .wbsc_i  (scatter_value_i >> 1),
    .re_i    (mem_re),
    .raddr_i (rd_addr_q),
    .rabs_o  (rabs),
    .rbsc_o  (rbsc)
  );

  bat_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_a_i (sum_a_q),
    .sum_b_i (sum_b_q),
    .count_i (count_q),
    .res_o   (div_res)
  );

endmodule

`default_nettype wire

@@ rtl/bat_checker.sv @@
// ----------------------------------------------------------------------------
// bat_checker
// Port-level checks of the table lookup core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bat_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        func_i,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [39:0] mean_absorption_o,
  input wire [39:0] mean_backscatter_o,
  input wire [12:0] entries_averaged_o
);
  import bat_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mean_absorption_o)
      && $stable(mean_backscatter_o) && $stable(entries_averaged_o))
    else $error("stalled result changed");

  // A window always covers at least one entry
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entries_averaged_o != 13'd0)
    else $error("result with empty window");

  // A load item gives no result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (func_i == FUNC_LOAD) && !out_valid_o
      |=> !out_valid_o)
    else $error("load item produced a result");

  // A query keeps the input side busy until its result is written out
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (func_i == FUNC_QUERY) |=> in_stall_o)
    else $error("query accepted without going busy");

  a_result_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result issued while still busy");

endmodule

bind band_averaged_table_lookup_core bat_checker u_bat_checker (.*);

`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for band_averaged_table_lookup_core.
// Loads both spectral tables and runs band-averaged queries under reset,
// extreme and random register settings. Every mean is compared with an
// in-bench model of the tables, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import bat_pkg::*;

  localparam int DEPTH       = 4096;
  localparam int STEP        = 1;
  localparam int IDLE_LIMIT  = 20000;
  localparam int SETTLE_CYC  = 80;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 32;

  typedef struct packed {
    logic [VAL_W-1:0] mean_abs;
    logic [VAL_W-1:0] mean_bsc;
    logic [12:0]      count;
  } band_mean_t;

  logic             clk_i              = 1'b0;
  logic             rst_ni             = 1'b0;
  logic             cfg_we_i           = 1'b0;
  logic [0:0]       cfg_idx_i          = REG_FIRST_WL;
  logic [12:0]      cfg_wdata_i        = '0;
  logic             in_valid_i         = 1'b0;
  logic             in_stall_o;
  logic             func_i             = FUNC_LOAD;
  logic [11:0]      entry_index_i      = '0;
  logic [VAL_W-1:0] absorption_value_i = '0;
  logic [VAL_W-1:0] scatter_value_i    = '0;
  logic [15:0]      wavelength_nm_i    = '0;
  logic [12:0]      bandwidth_nm_i     = '0;
  logic             out_valid_o;
  logic             out_stall_i        = 1'b0;
  logic [VAL_W-1:0] mean_absorption_o;
  logic [VAL_W-1:0] mean_backscatter_o;
  logic [12:0]      entries_averaged_o;

  // Mirror of the tables and registers
  logic [VAL_W-1:0] absorb_tab [DEPTH];
  logic [VAL_W-1:0] backsc_tab [DEPTH];
  bit               loaded     [DEPTH];
  logic [11:0]      first_wl;
  logic [12:0]      entries_reg;
  band_mean_t       pending_means [$];

  int  errors;
  int  loads_sent;
  int  queries_sent;
  int  means_checked;
  int  max_window;
  int  idle_count;
  int  stall_run;
  bit  calm;

  band_averaged_table_lookup_core #(
    .TABLE_DEPTH(DEPTH),
    .STEP_NM    (STEP)
  ) dut (.*);

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int clip(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Entries actually used for clamping after saturation
  function automatic int span();
    return clip(int'(entries_reg), 1, DEPTH);
  endfunction

  function automatic logic [VAL_W-1:0] rand40();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return r[VAL_W-1:0];
    endcase
  endfunction

  // Clamp the centre, then clip the window to the loaded range
  function automatic void window_bounds(input logic [15:0] wl, input logic [12:0] bw,
                                        output int lo, output int hi);
    int n;
    int centre;
    int half;
    n      = span();
    centre = clip((int'(wl) - int'(first_wl)) / STEP, 0, n - 1);
    half   = (int'(bw) / 2) / STEP;
    lo     = clip(centre - half, 0, n - 1);
    hi     = clip(centre + half, 0, n - 1);
  endfunction

  function automatic band_mean_t predict_means(input logic [15:0] wl, input logic [12:0] bw);
    int          lo;
    int          hi;
    logic [63:0] sum_a;
    logic [63:0] sum_b;
    logic [63:0] cnt;
    band_mean_t  r;
    window_bounds(wl, bw, lo, hi);
    sum_a  = '0;
    sum_b  = '0;
    for (int i = lo; i <= hi; i++) begin
      sum_a += 64'(absorb_tab[i]);
      sum_b += 64'(backsc_tab[i]);
    end
    cnt        = 64'(hi - lo + 1);
    if (hi - lo + 1 > max_window) max_window = hi - lo + 1;
    r.mean_abs = VAL_W'(sum_a / cnt);
    r.mean_bsc = VAL_W'(sum_b / cnt);
    r.count    = 13'(cnt);
    return r;
  endfunction

  // Drop valid, then wait
  task automatic hold_off(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic send_item(input logic f, input logic [11:0] idx,
                           input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] s,
                           input logic [15:0] wl, input logic [12:0] bw);
    if (!calm && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 15));
    in_valid_i         <= 1'b1;
    func_i             <= f;
    entry_index_i      <= idx;
    absorption_value_i <= a;
    scatter_value_i    <= s;
    wavelength_nm_i    <= wl;
    bandwidth_nm_i     <= bw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (f == FUNC_LOAD) begin
      absorb_tab[idx] = a;
      backsc_tab[idx] = s >> 1;
      loaded[idx]     = 1'b1;
      loads_sent++;
    end else begin
      pending_means.push_back(predict_means(wl, bw));
      queries_sent++;
    end
  endtask

  // Unused fields carry random noise
  task automatic load_entry(input logic [11:0] idx, input logic [VAL_W-1:0] a,
                            input logic [VAL_W-1:0] s);
    send_item(FUNC_LOAD, idx, a, s, 16'($urandom), 13'($urandom));
  endtask

  // Load every entry of the window that was never written, then query
  task automatic ask(input logic [15:0] wl, input logic [12:0] bw);
    int lo;
    int hi;
    window_bounds(wl, bw, lo, hi);
    for (int i = lo; i <= hi; i++) begin
      if (!loaded[i]) load_entry(12'(i), rand40(), rand40());
    end
    send_item(FUNC_QUERY, 12'($urandom), rand40(), rand40(), wl, bw);
  endtask

  // Hold the sender until every mean is back and the core is quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [12:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_FIRST_WL) first_wl = val[11:0];
    else entries_reg = val;
    @(posedge clk_i);
  endtask

  task automatic check_means();
    band_mean_t want;
    means_checked++;
    if (pending_means.size() == 0) begin
      report_mismatch("result with no query outstanding");
      return;
    end
    want = pending_means.pop_front();
    if (mean_absorption_o !== want.mean_abs)
      report_mismatch($sformatf("mean_absorption got %h want %h",
                                mean_absorption_o, want.mean_abs));
    if (mean_backscatter_o !== want.mean_bsc)
      report_mismatch($sformatf("mean_backscatter got %h want %h",
                                mean_backscatter_o, want.mean_bsc));
    if (entries_averaged_o !== want.count)
      report_mismatch($sformatf("entries_averaged got %0d want %0d",
                                entries_averaged_o, want.count));
  endtask

  // Result side: check accepted means, stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_means();
    if (calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      stall_run = $urandom_range(1, 15);
      out_stall_i <= ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_count <= 0;
    end else if (idle_count == IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("FAIL band_averaged_table_lookup_core");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  task automatic test_reset_registers();
    load_entry(12'd5, '1, '1);
    load_entry(12'd6, 40'h1, 40'h1);    // odd scatter loses its low bit
    ask(16'd205, 13'd0);
    ask(16'd206, 13'd1);
    ask(16'd0, 13'd0);                  // below the table
    ask(16'd65535, 13'd0);              // above the table
    ask(16'd210, 13'd40);               // window clipped at zero
    ask(16'd2440, 13'd30);              // window clipped at the top
    ask(16'd1324, 13'd64);
    ask(16'd1324, 13'd0);
    ask(16'd200, 13'd7);
    ask(16'hAAAA, 13'd21);
    ask(16'd2449, 13'd1);
  endtask

  task automatic test_register_extremes();
    settle();
    write_reg(REG_FIRST_WL, 13'd0);
    write_reg(REG_ENTRIES, 13'd1);
    ask(16'd0, 13'd0);
    ask(16'd65535, 13'd8191);
    ask(16'd1, 13'd2);
    settle();
    write_reg(REG_ENTRIES, 13'd0);      // saturates to one entry
    ask(16'd3, 13'd5);
    settle();
    write_reg(REG_FIRST_WL, 13'd4095);
    write_reg(REG_ENTRIES, 13'd4096);
    ask(16'd4095, 13'd0);
    ask(16'd0, 13'd3);
    ask(16'd65535, 13'd0);
    ask(16'd6143, 13'd200);             // wide window mid table
    ask(16'd8190, 13'd2);
    settle();
    write_reg(REG_ENTRIES, 13'd8191);   // saturates to the table depth
    ask(16'd65535, 13'd60);
    ask(16'd4100, 13'd20);
  endtask

  task automatic test_random_traffic();
    int          n;
    int          base;
    logic [12:0] ent;
    logic [12:0] fwl;
    logic [15:0] wl;
    logic [12:0] bw;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph == PHASES - 1) calm = 1'b1;
      case ($urandom_range(0, 3))
        0: fwl = 13'd0;
        1: fwl = 13'd4095;
        default: fwl = 13'($urandom_range(0, 4095));
      endcase
      case ($urandom_range(0, 7))
        0: ent = 13'd0;
        1: ent = 13'($urandom_range(4097, 8191));
        2: ent = 13'($urandom_range(1000, 4096));
        default: ent = 13'($urandom_range(1, 300));
      endcase
      write_reg(REG_FIRST_WL, fwl);
      write_reg(REG_ENTRIES, ent);
      n    = span();
      base = int'($urandom_range(0, n - 1));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          load_entry(12'($urandom), rand40(), rand40());
        end else begin
          // mostly around one spot of the loaded range, now and then anywhere
          case ($urandom_range(0, 7))
            0: wl = 16'($urandom);
            1: wl = 16'($urandom_range(0, int'(first_wl)));
            default: wl = 16'(clip(int'(first_wl) + (base + int'($urandom_range(0, 23))) * STEP,
                                   0, 65535));
          endcase
          if (n <= 64 && $urandom_range(0, 9) == 0) bw = 13'($urandom);
          else bw = 13'($urandom_range(0, 12));
          ask(wl, bw);
        end
      end
    end
  endtask

  initial begin
    first_wl    = FIRST_WL_RST;
    entries_reg = ENTRIES_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_registers();
    test_register_extremes();
    test_random_traffic();
    settle();
    $display("run: %0d loads, %0d queries, %0d means checked", loads_sent, queries_sent,
             means_checked);
    $display("run: reset and extreme registers, %0d random settings, windows up to %0d entries",
             PHASES, max_window);
    if (errors == 0) begin
      $display("PASS band_averaged_table_lookup_core");
    end else begin
      $display("FAIL band_averaged_table_lookup_core");
    end
    $finish;
  end

endmodule
